### rtl/core/pcmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcmm_pkg;

   localparam int CHANNELS_DEFAULT  = 8;
   localparam int MEM_DEPTH_DEFAULT = 65536;

   localparam int OP_W     = 3;
   localparam int ADDR_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 17;
   localparam int CH_W     = 3;
   localparam int POS_W    = 19;
   localparam int SAMPLE_W = 16;

   localparam int SAMPLE_MAX = 32767;

   // command queue between front and engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
   localparam logic [OP_W-1:0] OP_PLAY   = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
   localparam logic [OP_W-1:0] OP_RESUME = 3'd4;

   typedef enum logic [2:0] {
      KIND_NOP    = 3'd0,
      KIND_TICK   = 3'd1,
      KIND_LOAD   = 3'd2,
      KIND_PLAY   = 3'd3,
      KIND_STOP   = 3'd4,
      KIND_RESUME = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [ADDR_W-1:0]     address;
      logic [BYTE_W-1:0]     byte_value;
      logic [POS_W-1:0]      limit;
      logic                  loop_flag;
      logic [CH_W-1:0]       channel;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/core/pcm_channel_mixer.sv
`timescale 1ns / 1ps
`default_nettype none

// Multichannel sample player and mixer with queue-style ports on both sides.
// Items enter a two-entry command queue, so up to two can be pushed while the
// engine is busy or a result waits to be popped. Load, play, stop, resume and
// unknown codes are carried out as the engine takes them. A tick walks the
// channels one per cycle through the single read port of the sample memory,
// then drains the read pipeline and clamps the sum. One result is held at a
// time, and the engine starts the next item once that result has been popped.
// MEM_DEPTH must be a power of two, which the block itself does not enforce;
// addresses wrap at the memory size. Sample memory is not cleared by reset,
// so bytes must be loaded before a channel plays them.
module pcm_channel_mixer #(
   parameter int CHANNELS  = pcmm_pkg::CHANNELS_DEFAULT,
   parameter int MEM_DEPTH = pcmm_pkg::MEM_DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic [pcmm_pkg::OP_W-1:0]             req_operation,
   input  wire logic [pcmm_pkg::ADDR_W-1:0]           req_address,
   input  wire logic [pcmm_pkg::BYTE_W-1:0]           req_byte_value,
   input  wire logic [pcmm_pkg::LEN_W-1:0]            req_length,
   input  wire logic                                  req_loop_flag,
   input  wire logic [pcmm_pkg::CH_W-1:0]             req_channel,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic signed [pcmm_pkg::SAMPLE_W-1:0]       rsp_sample,
   output logic [pcmm_pkg::CH_W-1:0]                  rsp_assigned_channel,
   output logic                                       rsp_status,
   output logic                                       rsp_clipped
);

   logic              cmd_valid;
   logic              cmd_take;
   pcmm_pkg::cmd_type cmd;
   logic              rsp_valid;

   pcmm_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_byte_value (req_byte_value),
      .req_length     (req_length),
      .req_loop_flag  (req_loop_flag),
      .req_channel    (req_channel),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd            (cmd)
   );

   pcmm_engine #(
      .CHANNELS  (CHANNELS),
      .MEM_DEPTH (MEM_DEPTH)
   ) u_engine (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (cmd_valid),
      .cmd_take             (cmd_take),
      .cmd                  (cmd),
      .rsp_valid            (rsp_valid),
      .rsp_pop              (rsp_pop),
      .rsp_sample           (rsp_sample),
      .rsp_assigned_channel (rsp_assigned_channel),
      .rsp_status           (rsp_status),
      .rsp_clipped          (rsp_clipped)
   );

   assign rsp_empty = !rsp_valid;

endmodule

`default_nettype wire

### rtl/core/pcmm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pcmm_front #(
   parameter int CHANNELS = pcmm_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [pcmm_pkg::OP_W-1:0]       req_operation,
   input  wire logic [pcmm_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [pcmm_pkg::BYTE_W-1:0]     req_byte_value,
   input  wire logic [pcmm_pkg::LEN_W-1:0]      req_length,
   input  wire logic                            req_loop_flag,
   input  wire logic [pcmm_pkg::CH_W-1:0]       req_channel,
   output logic                                 cmd_valid,
   input  wire logic                            cmd_take,
   output pcmm_pkg::cmd_type                    cmd
);

   pcmm_pkg::cmd_type                      q_ff [pcmm_pkg::QUEUE_DEPTH];
   pcmm_pkg::cmd_type                      cmd_new;
   logic [pcmm_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pcmm_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pcmm_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                                   push_ok;
   logic                                   pop_ok;
   logic                                   channel_ok;

   // classify the incoming item
   always_comb begin
      channel_ok         = 32'(req_channel) < CHANNELS;
      cmd_new.address    = req_address;
      cmd_new.byte_value = req_byte_value;
      cmd_new.limit      = {req_length, 2'b00};
      cmd_new.loop_flag  = req_loop_flag;
      cmd_new.channel    = req_channel;
      case (req_operation)
         pcmm_pkg::OP_TICK:   cmd_new.kind = pcmm_pkg::KIND_TICK;
         pcmm_pkg::OP_LOAD:   cmd_new.kind = pcmm_pkg::KIND_LOAD;
         pcmm_pkg::OP_PLAY:   cmd_new.kind = pcmm_pkg::KIND_PLAY;
         pcmm_pkg::OP_STOP:   cmd_new.kind = channel_ok ? pcmm_pkg::KIND_STOP
                                                        : pcmm_pkg::KIND_NOP;
         pcmm_pkg::OP_RESUME: cmd_new.kind = channel_ok ? pcmm_pkg::KIND_RESUME
                                                        : pcmm_pkg::KIND_NOP;
         default:             cmd_new.kind = pcmm_pkg::KIND_NOP;
      endcase
   end

   assign req_full  = count_ff == pcmm_pkg::QUEUE_CNT_W'(pcmm_pkg::QUEUE_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

### rtl/core/pcmm_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module pcmm_engine #(
   parameter int CHANNELS  = pcmm_pkg::CHANNELS_DEFAULT,
   parameter int MEM_DEPTH = pcmm_pkg::MEM_DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  cmd_valid,
   output logic                                       cmd_take,
   input  wire pcmm_pkg::cmd_type                     cmd,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_pop,
   output logic signed [pcmm_pkg::SAMPLE_W-1:0]       rsp_sample,
   output logic [pcmm_pkg::CH_W-1:0]                  rsp_assigned_channel,
   output logic                                       rsp_status,
   output logic                                       rsp_clipped
);

   localparam int AW    = $clog2(MEM_DEPTH);
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SUM_W = (AW > pcmm_pkg::POS_W - 1) ? AW : pcmm_pkg::POS_W - 1;
   localparam int ACC_W = 18 + $clog2(CHANNELS);
   localparam int POS_W = pcmm_pkg::POS_W;
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(pcmm_pkg::SAMPLE_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                            state_ff, state_in;
   logic [CW-1:0]                        cnt_ff, cnt_in;
   logic                                 hit_ff, hit_in;
   logic signed [ACC_W-1:0]              acc_ff, acc_in;

   logic                                 active_ff [CHANNELS];
   logic                                 active_in [CHANNELS];
   logic [POS_W-1:0]                     pos_ff    [CHANNELS];
   logic [POS_W-1:0]                     pos_in    [CHANNELS];
   logic [POS_W-1:0]                     limit_ff  [CHANNELS];
   logic [POS_W-1:0]                     limit_in  [CHANNELS];
   logic [pcmm_pkg::ADDR_W-1:0]          base_ff   [CHANNELS];
   logic [pcmm_pkg::ADDR_W-1:0]          base_in   [CHANNELS];
   logic                                 loop_ff   [CHANNELS];
   logic                                 loop_in   [CHANNELS];

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [pcmm_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [pcmm_pkg::CH_W-1:0]            rsp_assigned_ff, rsp_assigned_in;
   logic                                 rsp_status_ff, rsp_status_in;
   logic                                 rsp_clipped_ff, rsp_clipped_in;

   logic [pcmm_pkg::BYTE_W-1:0]          mem [MEM_DEPTH];
   logic [pcmm_pkg::BYTE_W-1:0]          rd_data_ff;
   logic [AW-1:0]                        rd_addr;
   logic [AW-1:0]                        wr_addr;
   logic [SUM_W-1:0]                     addr_sum;
   logic                                 mem_we;

   logic                                 out_free;
   logic                                 free_found;
   logic [CW-1:0]                        free_idx;
   logic [CW-1:0]                        cmd_ch;
   logic [POS_W-1:0]                     cur_pos;
   logic [POS_W-1:0]                     pos_next;
   logic                                 cur_hit;
   logic signed [16:0]                   term;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign cmd_take = cmd_valid && out_free && (state_ff == ST_IDLE);
   assign cmd_ch   = CW'(cmd.channel);

   // lowest inactive channel
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = CW'(i);
         end
      end
   end

   // walk stage one: current channel and its memory address
   always_comb begin
      cur_pos  = pos_ff[cnt_ff];
      pos_next = cur_pos + 1'b1;
      cur_hit  = active_ff[cnt_ff] && (cur_pos < limit_ff[cnt_ff]);
      addr_sum = SUM_W'(base_ff[cnt_ff]) + SUM_W'(cur_pos[POS_W-1:2]);
      rd_addr  = addr_sum[AW-1:0];
      wr_addr  = AW'(cmd.address);
   end

   // walk stage two: widen d to d*257 - 32767
   assign term = $signed({1'b0, rd_data_ff, rd_data_ff}) - 17'sd32767;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      hit_in          = 1'b0;
      acc_in          = acc_ff;
      active_in       = active_ff;
      pos_in          = pos_ff;
      limit_in        = limit_ff;
      base_in         = base_ff;
      loop_in         = loop_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_pop;
      rsp_sample_in   = rsp_sample_ff;
      rsp_assigned_in = rsp_assigned_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_clipped_in  = rsp_clipped_ff;
      mem_we          = 1'b0;

      if (hit_ff) begin
         acc_in = acc_ff + ACC_W'(term);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               rsp_sample_in   = '0;
               rsp_assigned_in = '0;
               rsp_status_in   = 1'b0;
               rsp_clipped_in  = 1'b0;
               rsp_valid_in    = 1'b1;
               case (cmd.kind)
                  pcmm_pkg::KIND_TICK: begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_WALK;
                     cnt_in       = '0;
                     acc_in       = '0;
                  end
                  pcmm_pkg::KIND_LOAD: begin
                     mem_we = 1'b1;
                  end
                  pcmm_pkg::KIND_PLAY: begin
                     if (free_found) begin
                        limit_in[free_idx]  = cmd.limit;
                        pos_in[free_idx]    = '0;
                        base_in[free_idx]   = cmd.address;
                        active_in[free_idx] = 1'b1;
                        loop_in[free_idx]   = cmd.loop_flag;
                        rsp_assigned_in     = pcmm_pkg::CH_W'(free_idx);
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  pcmm_pkg::KIND_STOP: begin
                     active_in[cmd_ch] = 1'b0;
                  end
                  pcmm_pkg::KIND_RESUME: begin
                     active_in[cmd_ch] = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            hit_in = cur_hit;
            if (cur_hit) begin
               if (pos_next >= limit_ff[cnt_ff]) begin
                  if (loop_ff[cnt_ff]) begin
                     pos_in[cnt_ff] = '0;
                  end else begin
                     pos_in[cnt_ff]    = pos_next;
                     active_in[cnt_ff] = 1'b0;
                  end
               end else begin
                  pos_in[cnt_ff] = pos_next;
               end
            end
            if (cnt_ff == CW'(CHANNELS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in    = 1'b1;
            rsp_assigned_in = '0;
            rsp_status_in   = 1'b0;
            if (acc_ff > ACC_MAX) begin
               rsp_sample_in  = pcmm_pkg::SAMPLE_W'(ACC_MAX);
               rsp_clipped_in = 1'b1;
            end else if (acc_ff < ACC_MIN) begin
               rsp_sample_in  = pcmm_pkg::SAMPLE_W'(ACC_MIN);
               rsp_clipped_in = 1'b1;
            end else begin
               rsp_sample_in  = pcmm_pkg::SAMPLE_W'(acc_ff);
               rsp_clipped_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            active_ff[i] <= 1'b0;
            pos_ff[i]    <= '0;
            limit_ff[i]  <= '0;
            base_ff[i]   <= '0;
            loop_ff[i]   <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         limit_ff     <= limit_in;
         base_ff      <= base_in;
         loop_ff      <= loop_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff          <= acc_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_assigned_ff <= rsp_assigned_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_clipped_ff  <= rsp_clipped_in;
   end

   // sample memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cmd.byte_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sample           = rsp_sample_ff;
   assign rsp_assigned_channel = rsp_assigned_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_clipped          = rsp_clipped_ff;

endmodule

`default_nettype wire

### rtl/core/pcmm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcmm_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_full,
   input wire logic                                  rsp_empty,
   input wire logic                                  rsp_pop,
   input wire logic signed [pcmm_pkg::SAMPLE_W-1:0]  rsp_sample,
   input wire logic [pcmm_pkg::CH_W-1:0]             rsp_assigned_channel,
   input wire logic                                  rsp_status,
   input wire logic                                  rsp_clipped
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_sample != 16'sh8000)
      else $error("sample outside clamp range");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_clipped |->
         (rsp_sample == 16'sd32767 || rsp_sample == -16'sd32767) && !rsp_status)
      else $error("clipped sample not at a rail");

   a_no_channel: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status |->
         rsp_sample == '0 && rsp_assigned_channel == '0 && !rsp_clipped)
      else $error("failed play carries data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_sample))
      else $error("waiting result changed");

endmodule

bind pcm_channel_mixer pcmm_checker u_checker (.*);

`default_nettype wire

### verif/pcm_mix_checker.sv
`timescale 1ns / 1ps

module pcm_mix_checker
   import pcmm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire logic                       req_full,
   input  wire logic [OP_W-1:0]            req_operation,
   input  wire logic [ADDR_W-1:0]          req_address,
   input  wire logic [BYTE_W-1:0]          req_byte_value,
   input  wire logic [LEN_W-1:0]           req_length,
   input  wire logic                       req_loop_flag,
   input  wire logic [CH_W-1:0]            req_channel,
   input  wire logic                       rsp_empty,
   input  wire logic                       rsp_pop,
   input  wire logic signed [SAMPLE_W-1:0] rsp_sample,
   input  wire logic [CH_W-1:0]            rsp_assigned_channel,
   input  wire logic                       rsp_status,
   input  wire logic                       rsp_clipped,
   output int                              failures,
   output int                              pending
);

   localparam int NUM_CH = CHANNELS_DEFAULT;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic [CH_W-1:0]            chan;
      logic                       status;
      logic                       clipped;
   } mixer_result_type;

   logic [BYTE_W-1:0] sample_mem [MEM_DEPTH_DEFAULT];
   logic              active     [NUM_CH];
   logic [POS_W-1:0]  position   [NUM_CH];
   logic [POS_W-1:0]  limit_pos  [NUM_CH];
   logic [ADDR_W-1:0] base_addr  [NUM_CH];
   logic              looping    [NUM_CH];

   mixer_result_type expected_mix[$];
   mixer_result_type want;

   // advances the channel state by one item and returns the result it causes
   function automatic mixer_result_type predict_mixer(
      input logic [OP_W-1:0]   op,
      input logic [ADDR_W-1:0] address,
      input logic [BYTE_W-1:0] value,
      input logic [LEN_W-1:0]  length,
      input logic              loop_f,
      input logic [CH_W-1:0]   chan
   );
      mixer_result_type  r;
      int                acc;
      int                free_ch;
      logic [ADDR_W-1:0] rd_addr;
      r.sample  = '0;
      r.chan    = '0;
      r.status  = 1'b0;
      r.clipped = 1'b0;
      case (op)
         OP_TICK: begin
            acc = 0;
            for (int c = 0; c < NUM_CH; c++) begin
               if (active[c] && position[c] < limit_pos[c]) begin
                  // each byte lasts four ticks, address wraps at the memory size
                  rd_addr = base_addr[c] + ADDR_W'(position[c] >> 2);
                  acc += int'(sample_mem[rd_addr]) * 257 - SAMPLE_MAX;
                  position[c] = position[c] + 1'b1;
                  if (position[c] >= limit_pos[c]) begin
                     if (looping[c]) position[c] = '0;
                     else active[c] = 1'b0;
                  end
               end
            end
            if (acc > SAMPLE_MAX) begin
               acc = SAMPLE_MAX;
               r.clipped = 1'b1;
            end else if (acc < -SAMPLE_MAX) begin
               acc = -SAMPLE_MAX;
               r.clipped = 1'b1;
            end
            r.sample = acc[SAMPLE_W-1:0];
         end
         OP_LOAD: begin
            sample_mem[address] = value;
         end
         OP_PLAY: begin
            free_ch = -1;
            for (int c = 0; c < NUM_CH; c++)
               if (!active[c] && free_ch < 0) free_ch = c;
            if (free_ch >= 0) begin
               limit_pos[free_ch] = {length, 2'b00};
               position[free_ch]  = '0;
               base_addr[free_ch] = address;
               active[free_ch]    = 1'b1;
               looping[free_ch]   = loop_f;
               r.chan = CH_W'(free_ch);
            end else begin
               r.status = 1'b1;
            end
         end
         OP_STOP: begin
            if (int'(chan) < NUM_CH) active[chan] = 1'b0;
         end
         OP_RESUME: begin
            if (int'(chan) < NUM_CH) active[chan] = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string field, input logic signed [31:0] want_v,
                              input logic signed [31:0] got_v);
      if (want_v !== got_v) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            active[c]    = 1'b0;
            position[c]  = '0;
            limit_pos[c] = '0;
            base_addr[c] = '0;
            looping[c]   = 1'b0;
         end
         expected_mix.delete();
         failures = 0;
         pending  = 0;
      end else begin
         // retire the outgoing transfer before adding the incoming one
         if (rsp_pop && !rsp_empty) begin
            if (expected_mix.size() == 0) begin
               failures++;
               $display("%0t: result with nothing expected, actual sample %0d chan %0d",
                        $time, rsp_sample, rsp_assigned_channel);
               $display("%0t: actual status %0d clip %0d", $time, rsp_status, rsp_clipped);
            end else begin
               want = expected_mix.pop_front();
               check_field("sample", want.sample, rsp_sample);
               check_field("assigned_channel", want.chan, rsp_assigned_channel);
               check_field("status", want.status, rsp_status);
               check_field("clipped", want.clipped, rsp_clipped);
            end
         end
         if (req_push && !req_full)
            expected_mix.push_back(predict_mixer(req_operation, req_address, req_byte_value,
                                                 req_length, req_loop_flag, req_channel));
         pending = expected_mix.size();
      end
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import pcmm_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int RUN_CAP      = 300;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [OP_W-1:0]            req_operation = '0;
   logic [ADDR_W-1:0]          req_address = '0;
   logic [BYTE_W-1:0]          req_byte_value = '0;
   logic [LEN_W-1:0]           req_length = '0;
   logic                       req_loop_flag = 1'b0;
   logic [CH_W-1:0]            req_channel = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic [CH_W-1:0]            rsp_assigned_channel;
   logic                       rsp_status;
   logic                       rsp_clipped;

   int fail_count;
   int pending_count;

   // bytes loaded so far; plays only cover loaded spans
   bit                written [65536];
   logic [ADDR_W-1:0] written_list[$];
   logic [ADDR_W-1:0] load_cursor = '0;

   int sent_items = 0;
   int sent_ticks = 0;
   int sent_loads = 0;
   int sent_plays = 0;
   int sent_chan_cmds = 0;
   bit send_burst = 1'b0;

   pcm_channel_mixer uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_operation(req_operation), .req_address(req_address),
      .req_byte_value(req_byte_value), .req_length(req_length),
      .req_loop_flag(req_loop_flag), .req_channel(req_channel),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_sample(rsp_sample), .rsp_assigned_channel(rsp_assigned_channel),
      .rsp_status(rsp_status), .rsp_clipped(rsp_clipped)
   );

   pcm_mix_checker mix_check (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_operation(req_operation), .req_address(req_address),
      .req_byte_value(req_byte_value), .req_length(req_length),
      .req_loop_flag(req_loop_flag), .req_channel(req_channel),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_sample(rsp_sample), .rsp_assigned_channel(rsp_assigned_channel),
      .rsp_status(rsp_status), .rsp_clipped(rsp_clipped),
      .failures(fail_count), .pending(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] value, input logic [LEN_W-1:0] len,
                            input logic loop_f, input logic [CH_W-1:0] chan);
      int gap;
      if (sent_items % 50 == 0) send_burst = ($urandom_range(3) == 0);
      gap = send_burst ? 0 : $urandom_range(8);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation  <= op;
      req_address    <= addr;
      req_byte_value <= value;
      req_length     <= len;
      req_loop_flag  <= loop_f;
      req_channel    <= chan;
      req_push       <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      sent_items++;
      case (op)
         OP_TICK:             sent_ticks++;
         OP_LOAD:             sent_loads++;
         OP_PLAY:             sent_plays++;
         OP_STOP, OP_RESUME:  sent_chan_cmds++;
         default: ;
      endcase
   endtask

   task automatic send_any(input logic [OP_W-1:0] op);
      send_item(op, ADDR_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom),
                1'($urandom), CH_W'($urandom));
   endtask

   task automatic load_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
      if (!written[addr]) begin
         written[addr] = 1'b1;
         written_list.push_back(addr);
      end
      send_item(OP_LOAD, addr, value, LEN_W'($urandom), 1'($urandom), CH_W'($urandom));
   endtask

   task automatic play(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                       input logic loop_f);
      send_item(OP_PLAY, addr, BYTE_W'($urandom), len, loop_f, CH_W'($urandom));
   endtask

   task automatic chan_cmd(input logic [OP_W-1:0] op, input logic [CH_W-1:0] chan);
      send_item(op, ADDR_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom),
                1'($urandom), chan);
   endtask

   // number of loaded bytes in a row starting at from, with wrap
   function automatic int written_run(input logic [ADDR_W-1:0] from, input int cap);
      int n;
      n = 0;
      while (n < cap && written[ADDR_W'(from + n)]) n++;
      return n;
   endfunction

   initial begin
      logic [ADDR_W-1:0] base;
      int                run;
      int                pick;
      logic [LEN_W-1:0]  len;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // span across the top of memory: two full-scale bytes, two zero bytes
      load_byte(16'hFFFF, 8'hFF);
      load_byte(16'h0000, 8'hFF);
      load_byte(16'h0001, 8'h00);
      load_byte(16'h0002, 8'h00);
      send_any(OP_TICK);
      // long length; stopped before it walks past the loaded bytes
      play(16'hFFFF, 17'h10000, 1'b0);
      play(16'hFFFF, 17'd4, 1'b1);
      repeat (4) send_any(OP_TICK);
      play(16'h0001, 17'h1FFFF, 1'b1);
      play(16'h1234, 17'd0, 1'b0);
      // positive clip, then negative clip as all three reach the zero bytes
      repeat (5) send_any(OP_TICK);
      chan_cmd(OP_RESUME, 3'd7);
      for (int code = OP_RESUME + 1; code < (1 << OP_W); code++) send_any(OP_W'(code));
      chan_cmd(OP_STOP, 3'd0);
      chan_cmd(OP_STOP, 3'd2);
      // reclaim the long channels with short safe spans
      play(16'hFFFF, 17'd0, 1'b1);
      play(16'h0000, 17'd3, 1'b0);
      play(16'h0001, 17'd2, 1'b1);
      play(16'hFFFF, 17'd1, 1'b0);
      play(16'h0000, 17'd2, 1'b1);
      // every channel busy now
      play(16'hFFFF, 17'h1FFFF, 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            // hold the input idle until everything sent so far has come back
            req_push <= 1'b0;
            while (pending_count != 0) @(negedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 15) begin
            if ($urandom_range(5) == 0) begin
               if ($urandom_range(3) == 0) begin
                  load_cursor = ADDR_W'($urandom_range(16'hFFFF, 16'hFFE0));
               end else begin
                  load_cursor = ADDR_W'($urandom);
               end
            end else begin
               load_cursor++;
            end
            load_byte(load_cursor, BYTE_W'($urandom));
         end else if (pick < 28) begin
            base = written_list[$urandom_range(written_list.size() - 1)];
            run = written_run(base, RUN_CAP);
            len = ($urandom_range(7) == 0) ? '0 : LEN_W'($urandom_range(run, 1));
            play(base, len, 1'($urandom));
         end else if (pick < 38) begin
            chan_cmd(OP_STOP, CH_W'($urandom));
         end else if (pick < 45) begin
            chan_cmd(OP_RESUME, CH_W'($urandom));
         end else if (pick < 48) begin
            send_any(OP_W'($urandom_range((1 << OP_W) - 1, OP_RESUME + 1)));
         end else begin
            send_any(OP_TICK);
         end
      end
      req_push <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("ran %0d items: %0d ticks, %0d loads, %0d plays, %0d stop/resume",
               sent_items, sent_ticks, sent_loads, sent_plays, sent_chan_cmds);
      $display("sample memory touched at %0d addresses", written_list.size());
      if (fail_count == 0 && pending_count == 0) begin
         $display("pcm_channel_mixer verification clean");
      end else begin
         $display("pcm_channel_mixer verification failed");
      end
      $finish;
   end

   // result side: random stalls between transfers, with stall-free stretches
   initial begin
      int  stall;
      int  pops;
      bit  pop_burst;
      pops = 0;
      pop_burst = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (pops % 40 == 0) pop_burst = ($urandom_range(3) == 0);
         stall = pop_burst ? 0 : $urandom_range(8);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
         pops++;
      end
   end

   initial begin
      #5_000_000;
      $display("pcm_channel_mixer verification failed");
      $finish;
   end

endmodule
